@@ design/ptbl_pkg.sv @@
// ----------------------------------------------------------------------------
// ptbl_pkg
// shared types and constants of the two-level page table engine
// ----------------------------------------------------------------------------
package ptbl_pkg;

   localparam int DIR_ENTRIES_DEF   = 16;
   localparam int TABLE_ENTRIES_DEF = 1024;

   localparam int WORD_W  = 32;
   localparam int FLAGS_W = 12;
   localparam int FRAME_W = WORD_W - FLAGS_W;
   localparam int IDX_W   = 10;
   localparam int FUNC_W  = 2;

   // flag bit positions
   localparam int FLAG_PRESENT  = 0;
   localparam int FLAG_WRITABLE = 1;
   localparam int FLAG_USER     = 2;
   localparam int FLAG_LARGE    = 7;

   // present and large set on every large page directory entry
   localparam logic [FLAGS_W-1:0] LARGE_FLAGS = 12'h081;
   // fresh table directory entry: present and writable, zero table base
   localparam logic [WORD_W-1:0]  DIR_TABLE_INIT = 32'h0000_0003;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_MAP   = 2'd0,
      FUNC_UNMAP = 2'd1,
      FUNC_SET   = 2'd2,
      FUNC_XLATE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   typedef struct packed {
      logic              dir_we;
      logic [WORD_W-1:0] dir_wdata;
      logic              tbl_we;
      logic [WORD_W-1:0] tbl_wdata;
      logic              ok;
      logic [WORD_W-1:0] phys;
   } exec_out_type;

endpackage

@@ design/ptbl_ram.sv @@
// ----------------------------------------------------------------------------
// ptbl_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module ptbl_ram #(
   parameter int DEPTH  = ptbl_pkg::DIR_ENTRIES_DEF,
   parameter int ADDR_W = 4
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [ADDR_W-1:0]           waddr,
   input  logic [ptbl_pkg::WORD_W-1:0] wdata,
   input  logic                        re,
   input  logic [ADDR_W-1:0]           raddr,
   output logic [ptbl_pkg::WORD_W-1:0] rdata
);

   logic [ptbl_pkg::WORD_W-1:0] mem [DEPTH];
   logic [ptbl_pkg::WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/ptbl_exec.sv @@
// ----------------------------------------------------------------------------
// ptbl_exec
// decides write-back and response from the fetched directory and table entry
// ----------------------------------------------------------------------------
module ptbl_exec (
   input  logic [ptbl_pkg::FUNC_W-1:0]  func,
   input  logic [ptbl_pkg::WORD_W-1:0]  vaddr,
   input  logic [ptbl_pkg::WORD_W-1:0]  paddr,
   input  logic [ptbl_pkg::FLAGS_W-1:0] page_flags,
   input  logic                         in_range,
   input  logic [ptbl_pkg::WORD_W-1:0]  dent,
   input  logic [ptbl_pkg::WORD_W-1:0]  tent,
   output ptbl_pkg::exec_out_type       res
);

   localparam int FW = ptbl_pkg::FLAGS_W;
   localparam int WW = ptbl_pkg::WORD_W;

   logic [ptbl_pkg::FRAME_W-1:0] pa_frame;
   logic [ptbl_pkg::FRAME_W-1:0] te_frame;
   logic                         d_present;
   logic                         d_large;
   logic                         t_present;

   assign pa_frame  = paddr[WW-1:FW];
   assign te_frame  = tent[WW-1:FW];
   assign d_present = dent[ptbl_pkg::FLAG_PRESENT];
   assign d_large   = dent[ptbl_pkg::FLAG_LARGE];
   assign t_present = tent[ptbl_pkg::FLAG_PRESENT];

   always_comb begin
      res = '0;
      if (in_range) begin
         case (ptbl_pkg::func_type'(func))
            ptbl_pkg::FUNC_MAP: begin
               if (page_flags[ptbl_pkg::FLAG_LARGE]) begin
                  // both sides must sit on a 4 MB boundary
                  if (vaddr[21:FW] == '0 && paddr[21:FW] == '0) begin
                     res.dir_we    = 1'b1;
                     res.dir_wdata = {pa_frame, page_flags | ptbl_pkg::LARGE_FLAGS};
                     res.ok        = 1'b1;
                  end
               end else begin
                  // first use of this directory slot: table still holds reset zeros
                  if (!d_present) begin
                     res.dir_we    = 1'b1;
                     res.dir_wdata = ptbl_pkg::DIR_TABLE_INIT;
                     res.dir_wdata[ptbl_pkg::FLAG_USER] = page_flags[ptbl_pkg::FLAG_USER];
                  end
                  if (!(t_present && te_frame != pa_frame)) begin
                     res.tbl_we    = 1'b1;
                     res.tbl_wdata = {pa_frame, page_flags};
                     res.ok        = 1'b1;
                  end
               end
            end
            ptbl_pkg::FUNC_UNMAP: begin
               if (d_present && !d_large) begin
                  res.tbl_we    = 1'b1;
                  res.tbl_wdata = '0;
                  res.ok        = 1'b1;
               end
            end
            ptbl_pkg::FUNC_SET: begin
               if (d_present && !d_large) begin
                  res.tbl_we    = 1'b1;
                  res.tbl_wdata = {te_frame, page_flags};
                  res.ok        = 1'b1;
               end
            end
            ptbl_pkg::FUNC_XLATE: begin
               if (d_large) begin
                  res.ok   = 1'b1;
                  res.phys = {dent[WW-1:22], vaddr[21:0]};
               end else if (d_present && t_present) begin
                  res.ok   = 1'b1;
                  res.phys = {te_frame, vaddr[FW-1:0]};
               end
            end
            default: begin
               res = '0;
            end
         endcase
      end
   end

endmodule

@@ design/two_level_page_table_engine_unit.sv @@
// ----------------------------------------------------------------------------
// two_level_page_table_engine_unit
// two-level page table with map, unmap, set-flags and translate operations
// ----------------------------------------------------------------------------
// flow: a transferred request reads the directory and table ram, then execute
//   and write-back registers its result; req_stall stays high until execute
//   fires, so a new request waits; a stalled result holds the next execute
// reset: a clearing pass over all DIR_ENTRIES * TABLE_ENTRIES slots (16384 by
//   default) zeroes both rams, with req_stall high until it ends
// ----------------------------------------------------------------------------
module two_level_page_table_engine_unit #(
   parameter int DIR_ENTRIES   = ptbl_pkg::DIR_ENTRIES_DEF,
   parameter int TABLE_ENTRIES = ptbl_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ptbl_pkg::FUNC_W-1:0]  req_func,
   input  logic [ptbl_pkg::WORD_W-1:0]  req_vaddr,
   input  logic [ptbl_pkg::WORD_W-1:0]  req_paddr,
   input  logic [ptbl_pkg::FLAGS_W-1:0] req_page_flags,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_ok,
   output logic [ptbl_pkg::WORD_W-1:0]  rsp_phys_out
);

   localparam int WW         = ptbl_pkg::WORD_W;
   localparam int IW         = ptbl_pkg::IDX_W;
   localparam int SLOT_DEPTH = DIR_ENTRIES * TABLE_ENTRIES;
   localparam int DIR_AW     = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
   localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int SLOT_FW    = 2 * IW + 1;

   ptbl_pkg::state_type state_ff, state_in;
   logic [SLOT_AW-1:0]  clr_cnt_ff, clr_cnt_in;

   logic [ptbl_pkg::FUNC_W-1:0]  func_ff;
   logic [WW-1:0]                va_ff;
   logic [WW-1:0]                pa_ff;
   logic [ptbl_pkg::FLAGS_W-1:0] fl_ff;
   logic                         in_range_ff;
   logic [SLOT_AW-1:0]           slot_ff;
   logic [DIR_AW-1:0]            dir_idx_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff;
   logic [WW-1:0]       rsp_phys_ff;

   logic                accept;
   logic                exec_fire;
   logic                clearing;
   logic                clr_last;
   logic [IW-1:0]       di;
   logic [IW-1:0]       ti;
   logic [SLOT_FW-1:0]  slot_full;
   logic                in_range;

   logic                dir_we;
   logic [DIR_AW-1:0]   dir_waddr;
   logic [WW-1:0]       dir_wdata;
   logic [WW-1:0]       dir_rdata;
   logic                tbl_we;
   logic [SLOT_AW-1:0]  tbl_waddr;
   logic [WW-1:0]       tbl_wdata;
   logic [WW-1:0]       tbl_rdata;

   ptbl_pkg::exec_out_type ex;

   assign clearing  = (state_ff == ptbl_pkg::ST_CLEAR);
   assign clr_last  = (clr_cnt_ff == SLOT_AW'(SLOT_DEPTH - 1));
   assign req_stall = (state_ff != ptbl_pkg::ST_IDLE);
   assign accept    = req_valid && (state_ff == ptbl_pkg::ST_IDLE);
   assign exec_fire = (state_ff == ptbl_pkg::ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign di        = req_vaddr[WW-1:WW-IW];
   assign ti        = req_vaddr[WW-IW-1:WW-2*IW];
   assign slot_full = SLOT_FW'(di) * SLOT_FW'(TABLE_ENTRIES) + SLOT_FW'(ti);
   assign in_range  = ((IW+1)'(di) < (IW+1)'(DIR_ENTRIES)) &&
                      ((IW+1)'(ti) < (IW+1)'(TABLE_ENTRIES));

   // sweep owns the write ports while clearing
   assign dir_we    = clearing ? ((SLOT_FW'(clr_cnt_ff)) < SLOT_FW'(DIR_ENTRIES))
                               : (exec_fire && ex.dir_we);
   assign dir_waddr = clearing ? clr_cnt_ff[DIR_AW-1:0] : dir_idx_ff;
   assign dir_wdata = clearing ? '0 : ex.dir_wdata;
   assign tbl_we    = clearing || (exec_fire && ex.tbl_we);
   assign tbl_waddr = clearing ? clr_cnt_ff : slot_ff;
   assign tbl_wdata = clearing ? '0 : ex.tbl_wdata;

   ptbl_ram #(
      .DEPTH  (DIR_ENTRIES),
      .ADDR_W (DIR_AW)
   ) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .waddr (dir_waddr),
      .wdata (dir_wdata),
      .re    (accept),
      .raddr (di[DIR_AW-1:0]),
      .rdata (dir_rdata)
   );

   ptbl_ram #(
      .DEPTH  (SLOT_DEPTH),
      .ADDR_W (SLOT_AW)
   ) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (accept),
      .raddr (slot_full[SLOT_AW-1:0]),
      .rdata (tbl_rdata)
   );

   ptbl_exec u_exec (
      .func       (func_ff),
      .vaddr      (va_ff),
      .paddr      (pa_ff),
      .page_flags (fl_ff),
      .in_range   (in_range_ff),
      .dent       (dir_rdata),
      .tent       (tbl_rdata),
      .res        (ex)
   );

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ptbl_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_last) begin
               state_in = ptbl_pkg::ST_IDLE;
            end
         end
         ptbl_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ptbl_pkg::ST_EXEC;
            end
         end
         ptbl_pkg::ST_EXEC: begin
            if (exec_fire) begin
               state_in = ptbl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptbl_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptbl_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff     <= req_func;
         va_ff       <= req_vaddr;
         pa_ff       <= req_paddr;
         fl_ff       <= req_page_flags;
         in_range_ff <= in_range;
         slot_ff     <= slot_full[SLOT_AW-1:0];
         dir_idx_ff  <= di[DIR_AW-1:0];
      end
      if (exec_fire) begin
         rsp_ok_ff   <= ex.ok;
         rsp_phys_ff <= ex.phys;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_phys_out = rsp_phys_ff;

endmodule
